/* rtl/core/suv_pkg.sv */
// ----------------------------------------------------------------------------
// suv_pkg
// Shared sizes, operation and status codes, and the cell control word of the
// sorted unique set queue.
// ----------------------------------------------------------------------------
package suv_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int IN_W     = ((FUNC_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_W    = ((STATUS_W + KEY_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_CMP  = 2'd1,
        CELL_INS  = 2'd2,
        CELL_DEL  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic              pop;
        logic [KEY_W-1:0]  key;
    } t_cell_ctrl;

endpackage

/* rtl/core/suv_cell.sv */
// ----------------------------------------------------------------------------
// suv_cell
// One slot of the sorted chain: holds a value, its valid bit and the compare
// flags against the current key; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module suv_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  suv_pkg::t_cell_ctrl        i_ctrl,
    input  logic [suv_pkg::KEY_W-1:0]  i_left_val,
    input  logic                       i_left_valid,
    input  logic                       i_left_lt,
    input  logic [suv_pkg::KEY_W-1:0]  i_right_val,
    input  logic                       i_right_valid,
    output logic [suv_pkg::KEY_W-1:0]  o_val,
    output logic                       o_valid,
    output logic                       o_lt,
    output logic                       o_eq
);

    logic [suv_pkg::KEY_W-1:0] r_val, n_val;
    logic                      r_valid, n_valid;
    logic                      r_lt, n_lt;
    logic                      r_eq, n_eq;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        n_lt    = r_lt;
        n_eq    = r_eq;
        unique case (i_ctrl.op)
            suv_pkg::CELL_CMP: begin
                n_lt = r_valid && ($signed(r_val) < $signed(i_ctrl.key));
                n_eq = r_valid && (r_val == i_ctrl.key);
            end
            suv_pkg::CELL_INS: begin
                // first slot not below the key takes it, the rest move up
                if (!r_lt) begin
                    if (i_left_lt) begin
                        n_val   = i_ctrl.key;
                        n_valid = 1'b1;
                    end else begin
                        n_val   = i_left_val;
                        n_valid = i_left_valid;
                    end
                end
            end
            suv_pkg::CELL_DEL: begin
                // close the gap from above; pop shifts every slot
                if (!r_lt || i_ctrl.pop) begin
                    n_val   = i_right_val;
                    n_valid = i_right_valid;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_lt    <= n_lt;
            r_eq    <= n_eq;
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

/* rtl/core/suv_chain.sv */
// ----------------------------------------------------------------------------
// suv_chain
// Row of CAPACITY cells kept in ascending order from slot 0; reports a match
// anywhere in the row and the head value.
// ----------------------------------------------------------------------------
module suv_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  suv_pkg::t_cell_ctrl        i_ctrl,
    output logic                       o_hit,
    output logic [suv_pkg::KEY_W-1:0]  o_head_val,
    output logic                       o_head_valid
);

    logic [suv_pkg::KEY_W-1:0] w_val   [suv_pkg::CAPACITY];
    logic                      w_valid [suv_pkg::CAPACITY];
    logic                      w_lt    [suv_pkg::CAPACITY];
    logic [suv_pkg::CAPACITY-1:0] w_eq;

    for (genvar g = 0; g < suv_pkg::CAPACITY; g++) begin : g_cell
        logic [suv_pkg::KEY_W-1:0] w_lval, w_rval;
        logic                      w_lvalid, w_llt, w_rvalid;

        if (g == 0) begin : g_head
            assign w_lval   = '0;
            assign w_lvalid = 1'b0;
            assign w_llt    = 1'b1;
        end else begin : g_mid_l
            assign w_lval   = w_val[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_llt    = w_lt[g-1];
        end

        if (g == suv_pkg::CAPACITY - 1) begin : g_tail
            assign w_rval   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_mid_r
            assign w_rval   = w_val[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        suv_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (i_ctrl),
            .i_left_val    (w_lval),
            .i_left_valid  (w_lvalid),
            .i_left_lt     (w_llt),
            .i_right_val   (w_rval),
            .i_right_valid (w_rvalid),
            .o_val         (w_val[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    assign o_hit        = |w_eq;
    assign o_head_val   = w_val[0];
    assign o_head_valid = w_valid[0];

endmodule

/* rtl/core/sorted_unique_set_queue.sv */
// ----------------------------------------------------------------------------
// sorted_unique_set_queue
// Ascending set of distinct signed 32-bit values held in a row of cells;
// insert, delete and pop-smallest, one result word per input word.
// ----------------------------------------------------------------------------
//  channel  dir  fields (lsb first)                      accepted when
//  s        in   func, key_value                         i_s_tvalid & o_s_tready
//  m        out  status, popped_value, entry_count       o_m_tvalid & i_m_tready
//
//  An item is handled in order: the accept edge latches the key and every cell
//  compares against it, and the apply step then shifts the whole row.
//  The next word is taken right after the shift, while the result waits.
//  A result stalled at the output holds the apply step; nothing is lost.
//  Reset clears all valid bits and the count.
// ----------------------------------------------------------------------------
module sorted_unique_set_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [suv_pkg::IN_W-1:0]   i_s_tdata,   // func[1:0], key_value[33:2]
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [suv_pkg::OUT_W-1:0]  o_m_tdata    // status[1:0], popped_value[33:2],
                                                    // entry_count[40:34]
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    suv_pkg::t_func               r_func;
    logic [suv_pkg::KEY_W-1:0]    r_key;
    logic [suv_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_out_valid;
    suv_pkg::t_status             r_status, n_status;
    logic [suv_pkg::KEY_W-1:0]    r_popped, n_popped;

    suv_pkg::t_cell_ctrl          w_ctrl;
    logic                         w_hit;
    logic [suv_pkg::KEY_W-1:0]    w_head_val;
    logic                         w_head_valid;
    logic                         w_accept;
    logic                         w_fire;
    logic                         w_full;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = (r_state == S_APPLY) && (!r_out_valid || i_m_tready);
    assign w_full     = (r_count == suv_pkg::CNT_W'(suv_pkg::CAPACITY));

    // start the compare on accept; decide the outcome and the row action in the apply cycle
    always_comb begin
        n_status     = suv_pkg::ST_DONE;
        n_popped     = '0;
        n_count      = r_count;
        w_ctrl.op    = suv_pkg::CELL_HOLD;
        w_ctrl.pop   = 1'b0;
        w_ctrl.key   = r_key;
        if (w_accept) begin
            w_ctrl.op  = suv_pkg::CELL_CMP;
            w_ctrl.key = i_s_tdata[suv_pkg::FUNC_W +: suv_pkg::KEY_W];
        end else begin
            unique case (r_func)
                suv_pkg::FUNC_INSERT: begin
                    if (w_hit) begin
                        n_status = suv_pkg::ST_MISS;
                    end else if (w_full) begin
                        n_status = suv_pkg::ST_FULL;
                    end else begin
                        w_ctrl.op = suv_pkg::CELL_INS;
                        n_count   = r_count + 1'b1;
                    end
                end
                suv_pkg::FUNC_DELETE: begin
                    if (!w_hit) begin
                        n_status = suv_pkg::ST_MISS;
                    end else begin
                        w_ctrl.op = suv_pkg::CELL_DEL;
                        n_count   = r_count - 1'b1;
                    end
                end
                suv_pkg::FUNC_POP: begin
                    if (r_count == '0) begin
                        n_status = suv_pkg::ST_EMPTY;
                    end else begin
                        w_ctrl.op  = suv_pkg::CELL_DEL;
                        w_ctrl.pop = 1'b1;
                        n_popped   = w_head_val;
                        n_count    = r_count - 1'b1;
                    end
                end
                default: ;
            endcase
            if (!w_fire) begin
                w_ctrl.op = suv_pkg::CELL_HOLD;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_APPLY;
            S_APPLY: if (w_fire)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    suv_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_hit        (w_hit),
        .o_head_val   (w_head_val),
        .o_head_valid (w_head_valid)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= suv_pkg::t_func'(i_s_tdata[suv_pkg::FUNC_W-1:0]);
            r_key  <= i_s_tdata[suv_pkg::FUNC_W +: suv_pkg::KEY_W];
        end
        if (w_fire) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = suv_pkg::OUT_W'({r_count, r_popped, r_status});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= suv_pkg::CNT_W'(suv_pkg::CAPACITY))
        else $error("stored count above capacity");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head_valid == (r_count != '0))
        else $error("head slot occupancy disagrees with count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_ctrl.op == suv_pkg::CELL_INS) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_miss_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_status != suv_pkg::ST_DONE) |=> $stable(r_count))
        else $error("refused operation changed the count");

endmodule

/* dv/sorted_unique_set_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_set_queue_tb
// Drives insert, delete and pop words into the sorted set queue and checks
// every result word against a shadow copy of the set. A directed opening
// covers extremes, duplicates, misses and the empty set; random traffic then
// swings the set between full and empty under four source and sink idling patterns.
// ----------------------------------------------------------------------------
module sorted_unique_set_queue_tb;

    localparam int CLK_HALF   = 6;
    localparam int STALL_MAX  = 4000;
    localparam int SEG_LEN    = 120;
    localparam int PHASE_OPS  = 175;
    localparam int PRINT_MAX  = 200;

    typedef struct packed {
        suv_pkg::t_status                status;
        logic [suv_pkg::KEY_W-1:0]       popped;
        logic [suv_pkg::CNT_W-1:0]       count;
    } t_set_result;

    // Shadow set and the results still owed by the block.
    class set_queue_checker;
        int          shadow_set[$];
        t_set_result owed_results[$];
        int          errors;

        task report(string msg);
            errors++;
            if (errors <= PRINT_MAX)
                $display("%0t ERROR: %s", $realtime, msg);
        endtask

        function int owed();
            return owed_results.size();
        endfunction

        function int size();
            return shadow_set.size();
        endfunction

        function int pick_present();
            return shadow_set[$urandom_range(shadow_set.size() - 1)];
        endfunction

        // First slot not below the key; hit when it equals the key.
        function int find_slot(int key, output bit hit);
            int i;
            i = 0;
            while (i < shadow_set.size() && shadow_set[i] < key)
                i++;
            hit = (i < shadow_set.size()) && (shadow_set[i] == key);
            return i;
        endfunction

        function void note_op(logic [suv_pkg::IN_W-1:0] word);
            suv_pkg::t_func fn;
            int             key;
            int             pos;
            bit             hit;
            t_set_result    res;
            fn  = suv_pkg::t_func'(word[suv_pkg::FUNC_W-1:0]);
            key = int'(word[suv_pkg::FUNC_W +: suv_pkg::KEY_W]);
            res.status = suv_pkg::ST_DONE;
            res.popped = '0;
            case (fn)
                suv_pkg::FUNC_INSERT: begin
                    pos = find_slot(key, hit);
                    if (hit)
                        res.status = suv_pkg::ST_MISS;
                    else if (shadow_set.size() >= suv_pkg::CAPACITY)
                        res.status = suv_pkg::ST_FULL;
                    else
                        shadow_set.insert(pos, key);
                end
                suv_pkg::FUNC_DELETE: begin
                    pos = find_slot(key, hit);
                    if (!hit)
                        res.status = suv_pkg::ST_MISS;
                    else
                        shadow_set.delete(pos);
                end
                suv_pkg::FUNC_POP: begin
                    if (shadow_set.size() == 0)
                        res.status = suv_pkg::ST_EMPTY;
                    else
                        res.popped = shadow_set.pop_front();
                end
                default: ;
            endcase
            res.count = suv_pkg::CNT_W'(shadow_set.size());
            owed_results.push_back(res);
        endfunction

        task check_word(logic [suv_pkg::OUT_W-1:0] word);
            t_set_result got;
            t_set_result want;
            got.status = suv_pkg::t_status'(word[suv_pkg::STATUS_W-1:0]);
            got.popped = word[suv_pkg::STATUS_W +: suv_pkg::KEY_W];
            got.count  = word[suv_pkg::STATUS_W + suv_pkg::KEY_W +: suv_pkg::CNT_W];
            if (owed_results.size() == 0) begin
                report($sformatf("result word %h with nothing owed", word));
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.popped !== want.popped)
                    report($sformatf("popped_value %h, want %h", got.popped, want.popped));
                if (got.count !== want.count)
                    report($sformatf("entry_count %0d, want %0d", got.count, want.count));
            end
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [suv_pkg::IN_W-1:0]      i_s_tdata = '0;    // func[1:0], key_value[33:2]
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [suv_pkg::OUT_W-1:0]     o_m_tdata;         // status[1:0], popped_value[33:2],
                                                      // entry_count[40:34]

    set_queue_checker   chk = new();
    int                 src_idle_pct;
    int                 sink_stall_pct;
    int                 stall_cycles;
    bit                 running;
    int                 op_index;

    sorted_unique_set_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Note the input word before checking the output word of the same edge.
    always @(posedge i_clk) begin
        if (running) begin
            if (i_s_tvalid && o_s_tready)
                chk.note_op(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                chk.check_word(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Called right after a falling edge; returns right after the next one
    // that follows acceptance.
    task send_op(suv_pkg::t_func fn, logic [suv_pkg::KEY_W-1:0] key);
        logic [suv_pkg::IN_W-1:0] word;
        word = '0;
        word[suv_pkg::FUNC_W-1:0] = fn;
        word[suv_pkg::FUNC_W +: suv_pkg::KEY_W] = key;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function logic [suv_pkg::KEY_W-1:0] any_key();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 35)
            return suv_pkg::KEY_W'($signed($urandom_range(60)) - 30);
        return $urandom;
    endfunction

    // Alternate fill-heavy and drain-heavy stretches so the set reaches both
    // full and empty.
    task random_op();
        bit                          filling;
        int                          r;
        suv_pkg::t_func              fn;
        logic [suv_pkg::KEY_W-1:0]   key;
        filling = ((op_index / SEG_LEN) % 2) == 0;
        r = $urandom_range(99);
        if (r < 3)
            fn = suv_pkg::FUNC_NONE;
        else if (filling)
            fn = (r < 92) ? suv_pkg::FUNC_INSERT :
                 (r < 96) ? suv_pkg::FUNC_DELETE : suv_pkg::FUNC_POP;
        else
            fn = (r < 18) ? suv_pkg::FUNC_INSERT :
                 (r < 54) ? suv_pkg::FUNC_DELETE : suv_pkg::FUNC_POP;
        key = any_key();
        if (chk.size() > 0) begin
            if (fn == suv_pkg::FUNC_INSERT && $urandom_range(99) < 10)
                key = chk.pick_present();
            if (fn == suv_pkg::FUNC_DELETE && $urandom_range(99) < 65)
                key = chk.pick_present();
        end
        send_op(fn, key);
        op_index++;
    endtask

    initial begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        stall_cycles   = 0;
        running        = 1'b0;
        op_index       = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        running  = 1'b1;
        @(negedge i_clk);

        // Empty store, unused selector, extremes, duplicates, misses.
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);
        send_op(suv_pkg::FUNC_DELETE, 32'h0000_0005);
        send_op(suv_pkg::FUNC_NONE,   32'h1234_5678);
        send_op(suv_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
        send_op(suv_pkg::FUNC_INSERT, 32'h8000_0000);
        send_op(suv_pkg::FUNC_INSERT, 32'h0000_0000);
        send_op(suv_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
        send_op(suv_pkg::FUNC_INSERT, 32'h0000_0001);
        send_op(suv_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
        send_op(suv_pkg::FUNC_INSERT, 32'h8000_0000);
        send_op(suv_pkg::FUNC_DELETE, 32'h0000_3039);
        send_op(suv_pkg::FUNC_DELETE, 32'h0000_0000);
        send_op(suv_pkg::FUNC_DELETE, 32'h7FFF_FFFF);
        send_op(suv_pkg::FUNC_POP,    32'hFFFF_FFFF);
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);
        send_op(suv_pkg::FUNC_NONE,   32'hFFFF_FFFF);
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);
        send_op(suv_pkg::FUNC_DELETE, 32'h8000_0000);
        send_op(suv_pkg::FUNC_INSERT, 32'hAAAA_AAAA);
        send_op(suv_pkg::FUNC_INSERT, 32'h5555_5555);
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);
        send_op(suv_pkg::FUNC_POP,    32'h0000_0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            repeat (PHASE_OPS) random_op();
        end
        i_s_tvalid <= 1'b0;
        sink_stall_pct = 0;

        while (chk.owed() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (chk.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/suv_pkg.sv
rtl/core/suv_cell.sv
rtl/core/suv_chain.sv
rtl/core/sorted_unique_set_queue.sv
dv/sorted_unique_set_queue_tb.sv
